/* rtl/core/bitmap_page_allocator_top_macros.svh */
// assertion macros for the page allocator rtl
`ifndef BITMAP_PAGE_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define BPA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("page allocator: same-cycle check failed");

// next-cycle implication, clocked on i_clk, off during reset
`define BPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("page allocator: next-cycle check failed");

`endif

/* rtl/core/bpa_pkg.sv */
// package: constants, codes and types of the page allocator
`timescale 1ns / 1ps
package bpa_pkg;

    localparam int NUM_PAGES_DEF     = 4096;
    localparam int MAP_WORD_BITS_DEF = 64;

    localparam int CMD_W   = 1;
    localparam int ORDER_W = 4;
    localparam int ALIGN_W = 4;
    localparam int PIDX_W  = 12;
    localparam int STAT_W  = 1;
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] FIRST_PAGE_RST = 13'd0;
    localparam logic [CFG_W-1:0] END_PAGE_RST   = 13'd4096;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK     = 1'b0;
    localparam logic [STAT_W-1:0] ST_NO_FIT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_PAGE   = 1'b1;

    // operation of the shared word unit
    typedef enum logic [1:0] {
        WU_FIND,
        WU_SET,
        WU_CLEAR
    } t_wu_op;

endpackage

/* rtl/core/bpa_item_if.sv */
// request channel: one allocate or free word
`timescale 1ns / 1ps
interface bpa_item_if;
    logic                         valid;
    logic                         ready;
    logic [bpa_pkg::CMD_W-1:0]    command;
    logic [bpa_pkg::ORDER_W-1:0]  order;
    logic [bpa_pkg::ALIGN_W-1:0]  align_log2;
    logic [bpa_pkg::PIDX_W-1:0]   page_index;

    modport source (output valid, command, order, align_log2, page_index, input ready);
    modport sink   (input valid, command, order, align_log2, page_index, output ready);
endinterface

/* rtl/core/bpa_result_if.sv */
// result channel: status and granted page
`timescale 1ns / 1ps
interface bpa_result_if;
    logic                        valid;
    logic                        ready;
    logic [bpa_pkg::STAT_W-1:0]  status;
    logic [bpa_pkg::PIDX_W-1:0]  granted_page;

    modport source (output valid, status, granted_page, input ready);
    modport sink   (input valid, status, granted_page, output ready);
endinterface

/* rtl/core/bpa_word_unit.sv */
// shared map word unit: range mask, first used page, set and clear
`timescale 1ns / 1ps
module bpa_word_unit #(
    parameter int MAP_WORD_BITS = bpa_pkg::MAP_WORD_BITS_DEF,
    localparam int BO_W = $clog2(MAP_WORD_BITS)
) (
    input  logic [MAP_WORD_BITS-1:0] i_word,
    input  logic [BO_W-1:0]          i_lo,
    input  logic [BO_W:0]            i_hi,
    input  bpa_pkg::t_wu_op          i_op,
    output logic                     o_hit,
    output logic [BO_W-1:0]          o_first,
    output logic [MAP_WORD_BITS-1:0] o_word
);

    logic [MAP_WORD_BITS-1:0] ones;
    logic [MAP_WORD_BITS-1:0] mask;
    logic [MAP_WORD_BITS-1:0] used;
    logic [MAP_WORD_BITS-1:0] lowest;

    // bits lo .. hi-1 of the word
    assign ones   = '1;
    assign mask   = (ones << i_lo) & ~(ones << i_hi);
    assign used   = i_word & mask;
    assign lowest = used & (~used + MAP_WORD_BITS'(1));
    assign o_hit  = |used;

    // one-hot to index
    always_comb begin
        o_first = '0;
        for (int b = 0; b < MAP_WORD_BITS; b++) begin
            if (lowest[b]) begin
                o_first = o_first | BO_W'(b);
            end
        end
    end

    always_comb begin
        case (i_op)
            bpa_pkg::WU_SET:   o_word = i_word | mask;
            bpa_pkg::WU_CLEAR: o_word = i_word & ~mask;
            default:           o_word = i_word;
        endcase
    end

endmodule

/* rtl/core/bitmap_page_allocator_top.sv */
// First-fit page allocator over a one-bit-per-page used map (1 = used).
// An allocate word asks for 2^order pages at a start that is a multiple of
// 2^align_log2 pages, within [first_managed_page, end_managed_page); both
// registers saturate at NUM_PAGES. The scan starts at the first aligned page,
// reads the used map one word per visit and asks the shared word unit for the
// lowest used page inside the candidate run; on a hit the candidate moves to
// the next aligned page past it, so only candidates that can still fit are
// visited. A found run is then marked used word by word; a free word clears
// 2^order bits from page_index (pages past the map are ignored). Each request
// gives exactly one result word: status 0 and the start page (0 for a free),
// or status 1 with page 0 when no run fits.
// Each map word visit is a registered memory read, then the word unit and
// write-back. Requests are taken one at a time. After reset a clearing pass
// zeroes each of the NUM_PAGES / MAP_WORD_BITS map words before the first
// request is taken; configuration writes are taken throughout.
`timescale 1ns / 1ps
`include "bitmap_page_allocator_top_macros.svh"
module bitmap_page_allocator_top #(
    parameter int NUM_PAGES     = bpa_pkg::NUM_PAGES_DEF,
    parameter int MAP_WORD_BITS = bpa_pkg::MAP_WORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bpa_item_if.sink                      i_in,
    bpa_result_if.source                  o_out,
    input  logic                          i_cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bpa_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int LOG_P     = $clog2(NUM_PAGES);
    // wide enough for page counts, alignment steps up to 2^15 and their sums
    localparam int SW        = ((LOG_P + 1) > 16 ? (LOG_P + 1) : 16) + 2;
    localparam int BO_W      = $clog2(MAP_WORD_BITS);
    localparam int MAP_WORDS = NUM_PAGES / MAP_WORD_BITS;
    localparam int WI_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    typedef enum logic [3:0] {
        S_CLEAR,   // zero the map after reset
        S_IDLE,    // wait for a request word
        S_A_INIT,  // align the first managed page
        S_A_CHK,   // bound check of the candidate
        S_A_RD,    // read map word under the scan position
        S_A_EV,    // look for a used page in the candidate run
        S_W_RD,    // read map word to be marked or released
        S_W_WR,    // modify and write it back
        S_PUSH     // post the result word
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [bpa_pkg::CFG_W-1:0] r_first_cfg, r_end_cfg;

    // request and scan registers
    logic [bpa_pkg::CMD_W-1:0]  r_cmd, n_cmd;
    logic [SW-1:0]              r_size, n_size;
    logic [SW-1:0]              r_astep, n_astep;
    logic [SW-1:0]              r_amask, n_amask;
    logic [SW-1:0]              r_i, n_i;
    logic [SW-1:0]              r_end, n_end;
    logic [SW-1:0]              r_pos, n_pos;
    logic [SW-1:0]              r_lim, n_lim;
    logic [bpa_pkg::STAT_W-1:0] r_res_status, n_res_status;
    logic [WI_W-1:0]            r_clr, n_clr;

    // output register
    logic                        r_out_valid, n_out_valid;
    logic [bpa_pkg::STAT_W-1:0]  r_out_status, n_out_status;
    logic [bpa_pkg::PIDX_W-1:0]  r_out_page, n_out_page;

    // used map
    logic [MAP_WORD_BITS-1:0] r_map [MAP_WORDS];
    logic [MAP_WORD_BITS-1:0] r_rd_data;
    logic [WI_W-1:0]          rd_addr, wr_addr;
    logic [MAP_WORD_BITS-1:0] wr_data;
    logic                     wr_en;

    // word unit hookup
    logic [SW-1:0]            base, word_top, rem, cand_next, first_clamp, end_clamp;
    logic [SW-1:0]            pidx_ext, free_lim, cand_sum;
    logic                     last_word;
    logic [BO_W:0]            hi;
    bpa_pkg::t_wu_op          wu_op;
    logic                     wu_hit;
    logic [BO_W-1:0]          wu_first;
    logic [MAP_WORD_BITS-1:0] wu_word;
    logic                     in_take, out_take;

    assign in_take  = i_in.valid && i_in.ready;
    assign out_take = r_out_valid && o_out.ready;

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.granted_page = r_out_page;

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_cfg <= bpa_pkg::FIRST_PAGE_RST;
            r_end_cfg   <= bpa_pkg::END_PAGE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bpa_pkg::CFG_FIRST_PAGE: r_first_cfg <= i_cfg_data;
                bpa_pkg::CFG_END_PAGE:   r_end_cfg   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // registers above the map size saturate
    assign first_clamp = (SW'(r_first_cfg) > SW'(NUM_PAGES)) ? SW'(NUM_PAGES)
                                                             : SW'(r_first_cfg);
    assign end_clamp   = (SW'(r_end_cfg) > SW'(NUM_PAGES)) ? SW'(NUM_PAGES)
                                                           : SW'(r_end_cfg);

    // position within the map word
    assign base      = {r_pos[SW-1:BO_W], {BO_W{1'b0}}};
    assign word_top  = base + SW'(MAP_WORD_BITS);
    assign rem       = r_lim - base;
    assign last_word = (rem <= SW'(MAP_WORD_BITS));
    assign hi        = last_word ? rem[BO_W:0] : (BO_W + 1)'(MAP_WORD_BITS);

    // next aligned candidate past the used page that was hit
    assign cand_next = ((base | SW'(wu_first)) + r_astep) & ~r_amask;
    assign cand_sum  = r_i + r_size;

    assign pidx_ext  = SW'(i_in.page_index);
    assign free_lim  = ((pidx_ext + (SW'(1) << i_in.order)) > SW'(NUM_PAGES))
                       ? SW'(NUM_PAGES) : (pidx_ext + (SW'(1) << i_in.order));

    assign wu_op = (r_state == S_A_EV)        ? bpa_pkg::WU_FIND  :
                   (r_cmd == bpa_pkg::CMD_ALLOC) ? bpa_pkg::WU_SET : bpa_pkg::WU_CLEAR;

    bpa_word_unit #(
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_word_unit (
        .i_word  (r_rd_data),
        .i_lo    (r_pos[BO_W-1:0]),
        .i_hi    (hi),
        .i_op    (wu_op),
        .o_hit   (wu_hit),
        .o_first (wu_first),
        .o_word  (wu_word)
    );

    // map memory, one write and one registered read per cycle
    assign rd_addr = r_pos[BO_W +: WI_W];
    assign wr_en   = (r_state == S_W_WR) || (r_state == S_CLEAR);
    assign wr_addr = (r_state == S_CLEAR) ? r_clr : r_pos[BO_W +: WI_W];
    assign wr_data = (r_state == S_CLEAR) ? '0 : wu_word;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map[wr_addr] <= wr_data;
        end
        r_rd_data <= r_map[rd_addr];
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_size       = r_size;
        n_astep      = r_astep;
        n_amask      = r_amask;
        n_i          = r_i;
        n_end        = r_end;
        n_pos        = r_pos;
        n_lim        = r_lim;
        n_res_status = r_res_status;
        n_clr        = r_clr;
        n_out_valid  = out_take ? 1'b0 : r_out_valid;
        n_out_status = r_out_status;
        n_out_page   = r_out_page;

        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + WI_W'(1);
                if (r_clr == WI_W'(MAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_take) begin
                    n_cmd        = i_in.command;
                    n_size       = SW'(1) << i_in.order;
                    n_astep      = SW'(1) << i_in.align_log2;
                    n_res_status = bpa_pkg::ST_OK;
                    if (i_in.command == bpa_pkg::CMD_FREE) begin
                        n_pos   = pidx_ext;
                        n_lim   = free_lim;
                        // nothing to release past the map
                        n_state = (pidx_ext < SW'(NUM_PAGES)) ? S_W_RD : S_PUSH;
                    end else begin
                        n_state = S_A_INIT;
                    end
                end
            end
            S_A_INIT: begin
                n_amask = r_astep - SW'(1);
                n_i     = (first_clamp + r_astep - SW'(1)) & ~(r_astep - SW'(1));
                n_end   = end_clamp;
                n_state = S_A_CHK;
            end
            S_A_CHK: begin
                if (cand_sum > r_end) begin
                    n_res_status = bpa_pkg::ST_NO_FIT;
                    n_state      = S_PUSH;
                end else begin
                    n_lim   = cand_sum;
                    n_pos   = r_i;
                    n_state = S_A_RD;
                end
            end
            S_A_RD: begin
                n_state = S_A_EV;
            end
            S_A_EV: begin
                if (wu_hit) begin
                    n_i     = cand_next;
                    n_state = S_A_CHK;
                end else if (last_word) begin
                    // whole run free: go mark it
                    n_pos   = r_i;
                    n_state = S_W_RD;
                end else begin
                    n_pos   = word_top;
                    n_state = S_A_RD;
                end
            end
            S_W_RD: begin
                n_state = S_W_WR;
            end
            S_W_WR: begin
                if (last_word) begin
                    n_state = S_PUSH;
                end else begin
                    n_pos   = word_top;
                    n_state = S_W_RD;
                end
            end
            S_PUSH: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_page   = ((r_cmd == bpa_pkg::CMD_ALLOC) &&
                                    (r_res_status == bpa_pkg::ST_OK))
                                   ? r_i[bpa_pkg::PIDX_W-1:0] : '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_cmd        <= n_cmd;
        r_size       <= n_size;
        r_astep      <= n_astep;
        r_amask      <= n_amask;
        r_i          <= n_i;
        r_end        <= n_end;
        r_pos        <= n_pos;
        r_lim        <= n_lim;
        r_res_status <= n_res_status;
        r_out_status <= n_out_status;
        r_out_page   <= n_out_page;
    end

    // a granted block is aligned and lies inside the managed range
    `BPA_ASSERT_NOW(a_grant_aligned, (r_state == S_PUSH && r_cmd == bpa_pkg::CMD_ALLOC && r_res_status == bpa_pkg::ST_OK), ((r_i & r_amask) == '0))
    `BPA_ASSERT_NOW(a_grant_in_range, (r_state == S_PUSH && r_cmd == bpa_pkg::CMD_ALLOC && r_res_status == bpa_pkg::ST_OK), (r_lim <= r_end && r_i >= first_clamp))
    // map reads stay inside the run being scanned or written
    `BPA_ASSERT_NOW(a_pos_in_run, (r_state == S_A_RD || r_state == S_W_RD), (r_pos < r_lim && r_lim <= SW'(NUM_PAGES)))
    // an accepted word always starts work
    `BPA_ASSERT_NEXT(a_accept_busy, in_take, (r_state != S_IDLE && r_state != S_CLEAR))

endmodule
